[hw/rtl/fckvt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fckvt_pkg
// Shared widths, defaults and request action codes of the fixed capacity
// key/value table.
// -----------------------------------------------------------------------------
package fckvt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_BITS      = 32;
   localparam int VALUE_BITS    = 32;
   localparam int ACTION_W      = 3;
   localparam int SLOT_W        = 4;
   localparam int CAP_W         = 5;
   localparam int USED_W        = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT    = 3'd0,
      ACT_UPDATE    = 3'd1,
      ACT_UPSERT    = 3'd2,
      ACT_ERASE     = 3'd3,
      ACT_LOOKUP    = 3'd4,
      ACT_READ_SLOT = 3'd5
   } action_type;

endpackage
`default_nettype wire

[hw/rtl/fixed_capacity_key_value_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fixed_capacity_key_value_table
// Unordered key/value table with linear first-match search, held in one
// synchronous entry memory that is scanned one slot per cycle.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Payload
//  req       in         req_valid / req_ready          action, key, value, slot_index
//  rsp       out        rsp_valid / rsp_ready          success, out_key, out_value,
//                                                      entries_used
//  csr       in         csr_write_enable (no wait)     capacity_limit
//
// A search visits the live entries one at a time, since the entry memory has a
// single read port. Read slot passes through the read state to the done state,
// or straight to the done state when the slot is out of range; an erase hit
// passes through the erase state after its search.
// One request is in work at a time; a result waits in the output register while
// the next request is accepted, and a finished request waits until that register
// is free. Reset clears the count and sets the capacity to 16; the entry memory
// is not cleared, as only data from live slots is ever used.
module fixed_capacity_key_value_table
   import fckvt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [ACTION_W-1:0]   req_action,
   input  wire  [KEY_BITS-1:0]   req_key,
   input  wire  [VALUE_BITS-1:0] req_value,
   input  wire  [SLOT_W-1:0]     req_slot_index,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_success,
   output logic [KEY_BITS-1:0]   rsp_out_key,
   output logic [VALUE_BITS-1:0] rsp_out_value,
   output logic [USED_W-1:0]     rsp_entries_used,
   input  wire                   csr_write_enable,
   input  wire  [CAP_W-1:0]      csr_write_data
);

   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int ENTRY_W = KEY_BITS + VALUE_BITS;
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ERASE,
      ST_MISS,
      ST_READ,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [ACTION_W-1:0]     action_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [VALUE_BITS-1:0]   value_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [IDX_W-1:0]        count_ff;
   logic [CAP_W-1:0]        cap_ff;
   logic                    res_ok_ff;
   logic [KEY_BITS-1:0]     res_key_ff;
   logic [VALUE_BITS-1:0]   res_value_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_success_ff;
   logic [KEY_BITS-1:0]     rsp_key_ff;
   logic [VALUE_BITS-1:0]   rsp_value_ff;
   logic [USED_W-1:0]       rsp_used_ff;

   logic [ENTRY_W-1:0]      entry_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]      rd_entry_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]      wr_entry;

   logic [KEY_BITS-1:0]     rd_key;
   logic [VALUE_BITS-1:0]   rd_value;
   logic [IDX_W-1:0]        idx_next;
   logic [IDX_W-1:0]        last_idx;
   logic [IDX_W-1:0]        slot_idx;
   logic                    hit;
   logic                    scan_end;
   logic                    can_append;
   logic                    is_append_action;
   logic                    out_free;

   assign rd_key   = rd_entry_ff[ENTRY_W-1 -: KEY_BITS];
   assign rd_value = rd_entry_ff[VALUE_BITS-1:0];
   assign idx_next = idx_ff + IDX_W'(1);
   assign last_idx = count_ff - IDX_W'(1);
   assign slot_idx = IDX_W'(req_slot_index);
   assign hit      = (state_ff == ST_SCAN) && (rd_key == key_ff);
   assign scan_end = (idx_next == count_ff);
   // Appending (insert or upsert) is bounded by both the programmed limit and the built depth.
   assign can_append = (count_ff < IDX_W'(cap_ff)) && (count_ff < DEPTH_IDX);
   assign is_append_action = (action_ff == ACT_INSERT) || (action_ff == ACT_UPSERT);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_entries_used = rsp_used_ff;

   // Memory port control. The scan reads the next slot ahead of each compare;
   // on an erase hit it fetches the last live entry instead.
   always_comb begin
      rd_addr  = idx_next[ADDR_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = idx_ff[ADDR_W-1:0];
      wr_entry = {key_ff, value_ff};
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_action == ACT_READ_SLOT) ? slot_idx[ADDR_W-1:0] : '0;
         end
         ST_SCAN: begin
            if (hit && (action_ff == ACT_ERASE)) begin
               rd_addr = last_idx[ADDR_W-1:0];
            end
            wr_en = hit && ((action_ff == ACT_UPDATE) || (action_ff == ACT_UPSERT));
         end
         ST_ERASE: begin
            wr_en    = 1'b1;
            wr_entry = rd_entry_ff;
         end
         ST_MISS: begin
            wr_en   = is_append_action && can_append;
            wr_addr = count_ff[ADDR_W-1:0];
         end
         ST_READ, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         // In the done state the output register is reloaded below instead.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  action_ff    <= req_action;
                  key_ff       <= req_key;
                  value_ff     <= req_value;
                  idx_ff       <= '0;
                  res_ok_ff    <= 1'b0;
                  res_key_ff   <= '0;
                  res_value_ff <= '0;
                  priority if (req_action == ACT_READ_SLOT) begin
                     state_ff <= ((slot_idx < count_ff) && (slot_idx < DEPTH_IDX)) ?
                                 ST_READ : ST_DONE;
                  end else if (req_action <= ACT_LOOKUP) begin
                     state_ff <= (count_ff == '0) ? ST_MISS : ST_SCAN;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  unique case (action_ff)
                     ACT_UPDATE, ACT_UPSERT: begin
                        res_ok_ff <= 1'b1;
                        state_ff  <= ST_DONE;
                     end
                     ACT_ERASE: begin
                        state_ff <= ST_ERASE;
                     end
                     ACT_LOOKUP: begin
                        res_ok_ff    <= 1'b1;
                        res_value_ff <= rd_value;
                        state_ff     <= ST_DONE;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end else if (scan_end) begin
                  state_ff <= ST_MISS;
               end else begin
                  idx_ff <= idx_next;
               end
            end
            ST_ERASE: begin
               // The last live entry is written into the freed slot.
               count_ff  <= last_idx;
               res_ok_ff <= 1'b1;
               state_ff  <= ST_DONE;
            end
            ST_MISS: begin
               if (is_append_action && can_append) begin
                  count_ff  <= count_ff + IDX_W'(1);
                  res_ok_ff <= 1'b1;
               end
               state_ff <= ST_DONE;
            end
            ST_READ: begin
               res_ok_ff    <= 1'b1;
               res_key_ff   <= rd_key;
               res_value_ff <= rd_value;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_success_ff <= res_ok_ff;
                  rsp_key_ff     <= res_key_ff;
                  rsp_value_ff   <= res_value_ff;
                  rsp_used_ff    <= count_ff[USED_W-1:0];
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[hw/rtl/fckvt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fckvt_checker
// Port-level checks of the key/value table, attached to the top level by bind.
// -----------------------------------------------------------------------------
module fckvt_checker
   import fckvt_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire                  rsp_success,
   input wire [KEY_BITS-1:0]   rsp_out_key,
   input wire [VALUE_BITS-1:0] rsp_out_value,
   input wire [USED_W-1:0]     rsp_entries_used
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success) &&
      $stable(rsp_out_key) && $stable(rsp_out_value) && $stable(rsp_entries_used))
      else $error("stalled transaction result changed");

   // A failed transaction reports zero key and value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_out_key == '0 && rsp_out_value == '0)
      else $error("failed transaction carries data");

   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in work");

   // A new result is only loaded after work on a request, never straight from idle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work cycle");

endmodule

bind fixed_capacity_key_value_table fckvt_checker u_fckvt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_success      (rsp_success),
   .rsp_out_key      (rsp_out_key),
   .rsp_out_value    (rsp_out_value),
   .rsp_entries_used (rsp_entries_used)
);
`default_nettype wire

[dv/fixed_capacity_key_value_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_key_value_table_tb
// Self-checking bench for the key/value table. A short table of directed
// transactions covers the empty table, duplicate keys, capacity limits and
// out-of-range slots. Random transactions over a small key pool follow, run
// under several capacity settings. Each response is compared with the expected
// result its row gives, or else with a shadow copy of the table kept inside the bench.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_table_tb;
   import fckvt_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   localparam int CLOCK_PERIOD    = 10;
   localparam int SETTLE_CYCLES   = 32;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int POOL_SIZE       = 24;
   localparam int MAX_PRINTED     = 40;

   // Action codes the block leaves undefined.
   localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

   typedef enum bit {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic                  success;
      logic [KEY_BITS-1:0]   out_key;
      logic [VALUE_BITS-1:0] out_value;
      logic [USED_W-1:0]     entries_used;
   } table_result_type;

   typedef struct {
      row_kind_type          kind;
      logic [ACTION_W-1:0]   action;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [SLOT_W-1:0]     slot;
      bit                    typed;
      table_result_type      result;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ACTION_W-1:0]   req_action;
   logic [KEY_BITS-1:0]   req_key;
   logic [VALUE_BITS-1:0] req_value;
   logic [SLOT_W-1:0]     req_slot_index;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_success;
   logic [KEY_BITS-1:0]   rsp_out_key;
   logic [VALUE_BITS-1:0] rsp_out_value;
   logic [USED_W-1:0]     rsp_entries_used;
   logic                  csr_write_enable;
   logic [CAP_W-1:0]      csr_write_data;

   fixed_capacity_key_value_table #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_key          (req_key),
      .req_value        (req_value),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_success      (rsp_success),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_value    (rsp_out_value),
      .rsp_entries_used (rsp_entries_used),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the table contents and the capacity register.
   logic [KEY_BITS-1:0]   key_store   [DEPTH];
   logic [VALUE_BITS-1:0] value_store [DEPTH];
   int                    live_entries;
   int                    capacity_setting;
   int                    peak_entries;

   table_result_type      pending_responses[$];
   logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];

   int mismatches;
   int requests_sent;
   int successes_seen;
   int csr_writes;
   int sender_burst;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   // ---------------------------------------------------------------------
   // Shadow table
   // ---------------------------------------------------------------------
   function automatic int find_key(input logic [KEY_BITS-1:0] key);
      for (int i = 0; i < live_entries; i++) begin
         if (key_store[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic bit append_entry(input logic [KEY_BITS-1:0] key,
                                       input logic [VALUE_BITS-1:0] value);
      int usable;
      // A capacity above the built depth behaves as the depth.
      usable = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
      if (live_entries >= usable) return 1'b0;
      key_store[live_entries]   = key;
      value_store[live_entries] = value;
      live_entries++;
      if (live_entries > peak_entries) peak_entries = live_entries;
      return 1'b1;
   endfunction

   function automatic table_result_type next_table_response(
      input logic [ACTION_W-1:0]   action,
      input logic [KEY_BITS-1:0]   key,
      input logic [VALUE_BITS-1:0] value,
      input logic [SLOT_W-1:0]     slot
   );
      table_result_type r;
      int               pos;
      int               last;
      r   = '0;
      pos = find_key(key);
      case (action)
         ACT_INSERT: begin
            if (pos < 0) r.success = append_entry(key, value);
         end
         ACT_UPDATE: begin
            if (pos >= 0) begin
               value_store[pos] = value;
               r.success        = 1'b1;
            end
         end
         ACT_UPSERT: begin
            if (pos >= 0) begin
               value_store[pos] = value;
               r.success        = 1'b1;
            end else begin
               r.success = append_entry(key, value);
            end
         end
         ACT_ERASE: begin
            // The last live entry moves into the freed slot.
            if (pos >= 0) begin
               last             = live_entries - 1;
               key_store[pos]   = key_store[last];
               value_store[pos] = value_store[last];
               live_entries     = last;
               r.success        = 1'b1;
            end
         end
         ACT_LOOKUP: begin
            if (pos >= 0) begin
               r.out_value = value_store[pos];
               r.success   = 1'b1;
            end
         end
         ACT_READ_SLOT: begin
            if (int'(slot) < live_entries) begin
               r.out_key   = key_store[slot];
               r.out_value = value_store[slot];
               r.success   = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.entries_used = USED_W'(live_entries);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random choices
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int sender_gap();
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      if ($urandom_range(39) == 0) sender_burst = $urandom_range(60, 20);
      return pick_gap();
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input bit filling);
      int r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 30) return ACT_INSERT;
         if (r < 50) return ACT_UPSERT;
         if (r < 60) return ACT_UPDATE;
         if (r < 70) return ACT_ERASE;
         if (r < 85) return ACT_LOOKUP;
      end else begin
         if (r < 12) return ACT_INSERT;
         if (r < 22) return ACT_UPSERT;
         if (r < 32) return ACT_UPDATE;
         if (r < 67) return ACT_ERASE;
         if (r < 82) return ACT_LOOKUP;
      end
      if (r < 97) return ACT_READ_SLOT;
      return r[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
   endfunction

   // Most keys come from a small pool so that searches hit often.
   function automatic logic [KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 95) return $urandom;
      return r[0] ? {KEY_BITS{1'b1}} : '0;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 90) return $urandom;
      return r[0] ? {VALUE_BITS{1'b1}} : '0;
   endfunction

   function automatic logic [CAP_W-1:0] capacity_for_phase(input int phase);
      case (phase)
         0:       return CAP_W'(31);
         1:       return CAP_W'(DEPTH);
         2:       return '0;
         3:       return CAP_W'(1);
         5:       return CAP_W'(DEPTH + 1);
         7:       return CAP_RESET;
         default: return CAP_W'($urandom_range(DEPTH - 1, 2));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------
   function automatic stim_row_type req_row(input logic [ACTION_W-1:0]   action,
                                            input logic [KEY_BITS-1:0]   key,
                                            input logic [VALUE_BITS-1:0] value,
                                            input logic [SLOT_W-1:0]     slot);
      stim_row_type row;
      row.kind   = ROW_REQUEST;
      row.action = action;
      row.key    = key;
      row.value  = value;
      row.slot   = slot;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [ACTION_W-1:0]   action,
                                              input logic [KEY_BITS-1:0]   key,
                                              input logic [VALUE_BITS-1:0] value,
                                              input logic [SLOT_W-1:0]     slot,
                                              input logic                  success,
                                              input logic [KEY_BITS-1:0]   out_key,
                                              input logic [VALUE_BITS-1:0] out_value,
                                              input int                    used);
      stim_row_type row;
      row                     = req_row(action, key, value, slot);
      row.typed               = 1'b1;
      row.result.success      = success;
      row.result.out_key      = out_key;
      row.result.out_value    = out_value;
      row.result.entries_used = USED_W'(used);
      return row;
   endfunction

   function automatic stim_row_type csr_row(input int capacity);
      stim_row_type row;
      row       = req_row(ACT_INSERT, '0, VALUE_BITS'(capacity), '0);
      row.kind  = ROW_CSR;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [ACTION_W-1:0]   action,
                               input logic [KEY_BITS-1:0]   key,
                               input logic [VALUE_BITS-1:0] value,
                               input logic [SLOT_W-1:0]     slot,
                               input bit                    typed,
                               input table_result_type      typed_result);
      int               gap;
      table_result_type predicted;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_key        <= key;
      req_value      <= value;
      req_slot_index <= slot;
      do @(posedge clock); while (!req_ready);
      predicted = next_table_response(action, key, value, slot);
      pending_responses.push_back(typed ? typed_result : predicted);
      requests_sent++;
   endtask

   // Leaves the block idle: no request offered, every response returned.
   task automatic drain_table();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] capacity);
      drain_table();
      csr_write_enable <= 1'b1;
      csr_write_data   <= capacity;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = int'(capacity);
      csr_writes++;
   endtask

   initial begin : rsp_ready_driver
      int run;
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         run = ($urandom_range(9) == 0) ? $urandom_range(300, 50) : $urandom_range(8, 1);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      table_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            if (rsp_success) successes_seen++;
            if (rsp_success !== want.success)
               report_mismatch($sformatf("success got %0b want %0b",
                                         rsp_success, want.success));
            if (rsp_out_key !== want.out_key)
               report_mismatch($sformatf("out_key got %08h want %08h",
                                         rsp_out_key, want.out_key));
            if (rsp_out_value !== want.out_value)
               report_mismatch($sformatf("out_value got %08h want %08h",
                                         rsp_out_value, want.out_value));
            if (rsp_entries_used !== want.entries_used)
               report_mismatch($sformatf("entries_used got %0d want %0d",
                                         rsp_entries_used, want.entries_used));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type     directed_rows[$];
      table_result_type no_result;
      bit               filling;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_INSERT;
      req_key          = '0;
      req_value        = '0;
      req_slot_index   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      no_result        = '0;
      live_entries     = 0;
      capacity_setting = int'(CAP_RESET);
      peak_entries     = 0;
      mismatches       = 0;
      requests_sent    = 0;
      successes_seen   = 0;
      csr_writes       = 0;
      sender_burst     = 0;
      foreach (key_pool[i]) key_pool[i] = $urandom;

      // Empty table after reset.
      directed_rows.push_back(known_row(ACT_READ_SLOT, '0, '0, '0, 0, '0, '0, 0));
      directed_rows.push_back(known_row(ACT_LOOKUP, '0, '0, '0, 0, '0, '0, 0));
      directed_rows.push_back(known_row(ACT_UPDATE, '0, 32'h1, '0, 0, '0, '0, 0));
      directed_rows.push_back(known_row(ACT_ERASE, '1, '0, '0, 0, '0, '0, 0));
      // Extreme keys and values, duplicate insert.
      directed_rows.push_back(known_row(ACT_INSERT, '0, '1, '0, 1, '0, '0, 1));
      directed_rows.push_back(known_row(ACT_INSERT, '0, 32'h1, '0, 0, '0, '0, 1));
      directed_rows.push_back(known_row(ACT_LOOKUP, '0, '0, '0, 1, '0, '1, 1));
      directed_rows.push_back(known_row(ACT_INSERT, '1, '0, '0, 1, '0, '0, 2));
      directed_rows.push_back(known_row(ACT_READ_SLOT, '0, '0, 4'd1, 1, '1, '0, 2));
      // Slots at and beyond the live count.
      directed_rows.push_back(known_row(ACT_READ_SLOT, '0, '0, 4'd2, 0, '0, '0, 2));
      directed_rows.push_back(known_row(ACT_READ_SLOT, '1, '1, '1, 0, '0, '0, 2));
      directed_rows.push_back(req_row(ACT_UPDATE, '0, 32'h1234_5678, '1));
      directed_rows.push_back(req_row(ACT_LOOKUP, '0, '0, '0));
      directed_rows.push_back(req_row(ACT_UPSERT, '1, 32'hA5A5_A5A5, '0));
      directed_rows.push_back(req_row(ACT_UPSERT, 32'h5A5A_5A5A, 32'h1, '0));
      directed_rows.push_back(known_row(ACT_UNUSED_6, '1, '1, '1, 0, '0, '0, 3));
      directed_rows.push_back(known_row(ACT_UNUSED_7, '0, '1, '0, 0, '0, '0, 3));
      // Erasing slot 0 pulls the last entry down into it.
      directed_rows.push_back(req_row(ACT_ERASE, '0, '0, '0));
      directed_rows.push_back(req_row(ACT_READ_SLOT, '0, '0, '0));
      directed_rows.push_back(req_row(ACT_LOOKUP, '1, '0, '0));
      // Table full at the configured capacity; updates still land.
      directed_rows.push_back(csr_row(2));
      directed_rows.push_back(known_row(ACT_INSERT, 32'h00C0_FFEE, '1, '0, 0, '0, '0, 2));
      directed_rows.push_back(known_row(ACT_UPSERT, 32'h00C0_FFEE, '1, '0, 0, '0, '0, 2));
      directed_rows.push_back(req_row(ACT_UPSERT, 32'h5A5A_5A5A, '1, '0));
      // Capacity lowered below the live count keeps every entry.
      directed_rows.push_back(csr_row(1));
      directed_rows.push_back(known_row(ACT_INSERT, 32'h0BAD_F00D, '0, '0, 0, '0, '0, 2));
      directed_rows.push_back(known_row(ACT_ERASE, 32'h5A5A_5A5A, '0, '0, 1, '0, '0, 1));
      directed_rows.push_back(csr_row(0));
      directed_rows.push_back(known_row(ACT_INSERT, '0, '0, '0, 0, '0, '0, 1));
      directed_rows.push_back(csr_row(31));
      directed_rows.push_back(req_row(ACT_INSERT, 32'h0BAD_F00D, '0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_capacity(directed_rows[i].value[CAP_W-1:0]);
         end else begin
            send_request(directed_rows[i].action, directed_rows[i].key,
                         directed_rows[i].value, directed_rows[i].slot,
                         directed_rows[i].typed, directed_rows[i].result);
         end
      end

      // Within each random phase, requests alternate between filling and draining the table.
      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(capacity_for_phase(phase));
         foreach (key_pool[i]) key_pool[i] = $urandom;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            filling = ((n / 50) % 2) == 0;
            send_request(pick_action(filling), pick_key(), pick_value(),
                         SLOT_W'($urandom_range(DEPTH - 1)), 1'b0, no_result);
         end
      end

      drain_table();
      if (pending_responses.size() != 0)
         report_mismatch("responses still outstanding at end of run");

      $display("Sent %0d transactions under %0d capacity settings; %0d succeeded.",
               requests_sent, csr_writes, successes_seen);
      $display("Table occupancy peaked at %0d of %0d entries; %0d mismatches.",
               peak_entries, DEPTH, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
